[hw/rtl/sparse_scatter_gather_dot_product_core_defines.svh]
`ifndef SPARSE_SCATTER_GATHER_DOT_PRODUCT_CORE_DEFINES_SVH
`define SPARSE_SCATTER_GATHER_DOT_PRODUCT_CORE_DEFINES_SVH

// checked outside reset
`define SSG_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");

// checked during reset as well
`define SSG_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");

`endif

[hw/rtl/ssg_pkg.sv]
package ssg_pkg;

  localparam int IDX_W   = 16;
  localparam int VAL_W   = 16;
  localparam int DELTA_W = 14;
  localparam int SCR_W   = 24;
  localparam int TERM_W  = SCR_W + DELTA_W;
  localparam int SCORE_W = 48;

  localparam int QDEPTH  = 4;
  localparam int QAW     = $clog2(QDEPTH);

  localparam logic [1:0] ACT_LOAD   = 2'd0;
  localparam logic [1:0] ACT_PROBE  = 2'd1;
  localparam logic [1:0] ACT_FINISH = 2'd2;

  localparam logic [1:0] KIND_BIN    = 2'd0;
  localparam logic [1:0] KIND_NEG    = 2'd1;
  localparam logic [1:0] KIND_WGT    = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam logic signed [DELTA_W-1:0] ONE_Q11     = 14'sd2048;
  localparam logic signed [DELTA_W-1:0] NEG_ONE_Q11 = -14'sd2048;
  localparam logic signed [VAL_W-1:0]   TWO_Q11     = 16'sd4096;
  localparam logic signed [VAL_W-1:0]   NEG_TWO_Q11 = -16'sd4096;

  localparam logic signed [SCR_W-1:0]   SCR_MAX   = {1'b0, {(SCR_W-1){1'b1}}};
  localparam logic signed [SCR_W-1:0]   SCR_MIN   = {1'b1, {(SCR_W-1){1'b0}}};
  localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
  localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_PROBE,
    OP_FINISH
  } op_kind_t;

  typedef struct packed {
    op_kind_t                   kind;
    logic [IDX_W-1:0]           idx;
    logic signed [DELTA_W-1:0]  delta;
  } op_t;

  typedef struct packed {
    logic clearing;
  } back_stat_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LD_WR,
    ST_PR_MUL,
    ST_PR_ACC,
    ST_FIN_WALK
  } back_state_t;

endpackage

[hw/rtl/ssg_ram.sv]
module ssg_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/ssg_front.sv]
module ssg_front #(
  parameter int NUM_FEATURES = 65536
) (
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [31:0]                 in_tdata,
  input  logic [3:0]                  in_tuser,
  input  ssg_pkg::back_stat_t         stat,
  output logic                        push_valid,
  input  logic                        push_ready,
  output ssg_pkg::op_t                push_op
);

  localparam logic [24:0] NF = 25'(NUM_FEATURES);

  logic [1:0]                         action;
  logic [1:0]                         kind;
  logic [ssg_pkg::IDX_W-1:0]          idx;
  logic signed [ssg_pkg::VAL_W-1:0]   val;
  logic                               in_range;
  logic                               keep;
  logic signed [ssg_pkg::DELTA_W-1:0] clamped;

  assign action   = in_tuser[1:0];
  assign kind     = in_tuser[3:2];
  assign idx      = in_tdata[15:0];
  assign val      = $signed(in_tdata[31:16]);
  assign in_range = {9'd0, idx} < NF;

  always_comb begin
    if (val > ssg_pkg::TWO_Q11) begin
      clamped = ssg_pkg::TWO_Q11[ssg_pkg::DELTA_W-1:0];
    end else if (val < ssg_pkg::NEG_TWO_Q11) begin
      clamped = ssg_pkg::NEG_TWO_Q11[ssg_pkg::DELTA_W-1:0];
    end else begin
      clamped = val[ssg_pkg::DELTA_W-1:0];
    end
  end

  // out-of-range probes add zero, so they are dropped like out-of-range loads
  always_comb begin
    push_op.idx   = idx;
    push_op.kind  = ssg_pkg::OP_FINISH;
    push_op.delta = ssg_pkg::ONE_Q11;
    keep          = 1'b0;
    case (kind)
      ssg_pkg::KIND_BIN: push_op.delta = ssg_pkg::ONE_Q11;
      ssg_pkg::KIND_NEG: push_op.delta = ssg_pkg::NEG_ONE_Q11;
      default:           push_op.delta = clamped;
    endcase
    case (action)
      ssg_pkg::ACT_LOAD: begin
        push_op.kind = ssg_pkg::OP_LOAD;
        keep         = in_range && (kind != ssg_pkg::KIND_UNUSED);
      end
      ssg_pkg::ACT_PROBE: begin
        push_op.kind = ssg_pkg::OP_PROBE;
        keep         = in_range && (kind != ssg_pkg::KIND_UNUSED);
      end
      ssg_pkg::ACT_FINISH: begin
        push_op.kind = ssg_pkg::OP_FINISH;
        keep         = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign in_tready  = push_ready && !stat.clearing;
  assign push_valid = in_tvalid && in_tready && keep;

endmodule

[hw/rtl/ssg_queue.sv]
module ssg_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  ssg_pkg::op_t  push_op,
  output logic          pop_valid,
  input  logic          pop_ready,
  output ssg_pkg::op_t  pop_op
);

  ssg_pkg::op_t               entries_r [ssg_pkg::QDEPTH];
  logic [ssg_pkg::QAW-1:0]    wr_r;
  logic [ssg_pkg::QAW-1:0]    rd_r;
  logic [ssg_pkg::QAW:0]      count_r;
  logic                       do_push;
  logic                       do_pop;

  assign push_ready = count_r != (ssg_pkg::QAW + 1)'(ssg_pkg::QDEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_op     = entries_r[rd_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      if (do_push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (do_pop) begin
        rd_r <= rd_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_r] <= push_op;
    end
  end

endmodule

[hw/rtl/ssg_back.sv]
module ssg_back #(
  parameter int NUM_FEATURES = 65536,
  parameter int MAX_LOADED   = 256
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         pop_valid,
  output logic                         pop_ready,
  input  ssg_pkg::op_t                 pop_op,
  output ssg_pkg::back_stat_t          stat,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [ssg_pkg::SCORE_W-1:0]  out_tdata,
  output logic [0:0]                   out_tuser
);

  localparam int DEPTH = (NUM_FEATURES < 65536) ? NUM_FEATURES : 65536;
  localparam int AW    = $clog2(DEPTH);
  localparam int LW    = (MAX_LOADED > 1) ? $clog2(MAX_LOADED) : 1;
  localparam int CW    = $clog2(MAX_LOADED + 1);

  ssg_pkg::back_state_t state_r, state_nxt;

  logic [AW-1:0]                        clr_r, clr_nxt;
  logic [CW-1:0]                        count_r, count_nxt;
  logic [CW-1:0]                        walk_r, walk_nxt;
  logic signed [ssg_pkg::SCORE_W-1:0]   score_r, score_nxt;
  logic                                 ovf_r, ovf_nxt;
  logic [AW-1:0]                        addr_r, addr_nxt;
  logic signed [ssg_pkg::DELTA_W-1:0]   delta_r, delta_nxt;
  logic signed [ssg_pkg::TERM_W-1:0]    term_r, term_nxt;
  logic                                 oval_r, oval_nxt;
  logic [ssg_pkg::SCORE_W-1:0]          oscore_r, oscore_nxt;
  logic                                 oovf_r, oovf_nxt;

  logic                                 s_we;
  logic [AW-1:0]                        s_waddr;
  logic [ssg_pkg::SCR_W-1:0]            s_wdata;
  logic [AW-1:0]                        s_raddr;
  logic [ssg_pkg::SCR_W-1:0]            s_rdata;
  logic                                 l_we;
  logic [LW-1:0]                        l_waddr;
  logic [AW-1:0]                        l_wdata;
  logic [LW-1:0]                        l_raddr;
  logic [AW-1:0]                        l_rdata;

  logic                                 out_free;
  logic                                 list_full;
  logic signed [ssg_pkg::SCR_W:0]       ld_sum;
  logic signed [ssg_pkg::SCR_W-1:0]     ld_sat;
  logic signed [ssg_pkg::SCORE_W:0]     sc_sum;
  logic signed [ssg_pkg::SCORE_W-1:0]   sc_sat;

  ssg_ram #(.WIDTH(ssg_pkg::SCR_W), .DEPTH(DEPTH)) u_scratch (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  ssg_ram #(.WIDTH(AW), .DEPTH(MAX_LOADED)) u_touched (
    .clk   (clk),
    .we    (l_we),
    .waddr (l_waddr),
    .wdata (l_wdata),
    .raddr (l_raddr),
    .rdata (l_rdata)
  );

  assign out_free  = !oval_r || out_tready;
  assign list_full = count_r == CW'(MAX_LOADED);

  assign ld_sum = {s_rdata[ssg_pkg::SCR_W-1], s_rdata}
                + {{(ssg_pkg::SCR_W + 1 - ssg_pkg::DELTA_W){delta_r[ssg_pkg::DELTA_W-1]}},
                   delta_r};
  assign ld_sat = (ld_sum[ssg_pkg::SCR_W] == ld_sum[ssg_pkg::SCR_W-1])
                ? ld_sum[ssg_pkg::SCR_W-1:0]
                : (ld_sum[ssg_pkg::SCR_W] ? ssg_pkg::SCR_MIN : ssg_pkg::SCR_MAX);

  assign sc_sum = {score_r[ssg_pkg::SCORE_W-1], score_r}
                + {{(ssg_pkg::SCORE_W + 1 - ssg_pkg::TERM_W){term_r[ssg_pkg::TERM_W-1]}},
                   term_r};
  assign sc_sat = (sc_sum[ssg_pkg::SCORE_W] == sc_sum[ssg_pkg::SCORE_W-1])
                ? sc_sum[ssg_pkg::SCORE_W-1:0]
                : (sc_sum[ssg_pkg::SCORE_W] ? ssg_pkg::SCORE_MIN : ssg_pkg::SCORE_MAX);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ssg_pkg::ST_CLEAR: begin
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = ssg_pkg::ST_IDLE;
        end
      end
      ssg_pkg::ST_IDLE: begin
        if (pop_valid) begin
          case (pop_op.kind)
            ssg_pkg::OP_LOAD: begin
              if (!list_full) begin
                state_nxt = ssg_pkg::ST_LD_WR;
              end
            end
            ssg_pkg::OP_PROBE: state_nxt = ssg_pkg::ST_PR_MUL;
            ssg_pkg::OP_FINISH: begin
              if (out_free && count_r != '0) begin
                state_nxt = ssg_pkg::ST_FIN_WALK;
              end
            end
            default: state_nxt = ssg_pkg::ST_IDLE;
          endcase
        end
      end
      ssg_pkg::ST_LD_WR:  state_nxt = ssg_pkg::ST_IDLE;
      ssg_pkg::ST_PR_MUL: state_nxt = ssg_pkg::ST_PR_ACC;
      ssg_pkg::ST_PR_ACC: state_nxt = ssg_pkg::ST_IDLE;
      ssg_pkg::ST_FIN_WALK: begin
        if (walk_r == count_r) begin
          state_nxt = ssg_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ssg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    pop_ready  = 1'b0;
    s_we       = 1'b0;
    s_waddr    = addr_r;
    s_wdata    = '0;
    s_raddr    = pop_op.idx[AW-1:0];
    l_we       = 1'b0;
    l_waddr    = count_r[LW-1:0];
    l_wdata    = pop_op.idx[AW-1:0];
    l_raddr    = walk_r[LW-1:0];
    clr_nxt    = clr_r;
    count_nxt  = count_r;
    walk_nxt   = walk_r;
    score_nxt  = score_r;
    ovf_nxt    = ovf_r;
    addr_nxt   = addr_r;
    delta_nxt  = delta_r;
    term_nxt   = term_r;
    oval_nxt   = oval_r && !out_tready;
    oscore_nxt = oscore_r;
    oovf_nxt   = oovf_r;
    case (state_r)
      ssg_pkg::ST_CLEAR: begin
        s_we    = 1'b1;
        s_waddr = clr_r;
        clr_nxt = clr_r + 1'b1;
      end
      ssg_pkg::ST_IDLE: begin
        if (pop_valid) begin
          case (pop_op.kind)
            ssg_pkg::OP_LOAD: begin
              pop_ready = 1'b1;
              if (list_full) begin
                ovf_nxt = 1'b1;
              end else begin
                addr_nxt  = pop_op.idx[AW-1:0];
                delta_nxt = pop_op.delta;
                l_we      = 1'b1;
                count_nxt = count_r + 1'b1;
              end
            end
            ssg_pkg::OP_PROBE: begin
              pop_ready = 1'b1;
              delta_nxt = pop_op.delta;
            end
            ssg_pkg::OP_FINISH: begin
              if (out_free) begin
                pop_ready  = 1'b1;
                oval_nxt   = 1'b1;
                oscore_nxt = score_r;
                oovf_nxt   = ovf_r;
                score_nxt  = '0;
                ovf_nxt    = 1'b0;
                if (count_r != '0) begin
                  walk_nxt = CW'(1);
                end
              end
            end
            default: pop_ready = 1'b1;
          endcase
        end
      end
      ssg_pkg::ST_LD_WR: begin
        s_we    = 1'b1;
        s_waddr = addr_r;
        s_wdata = ld_sat;
      end
      ssg_pkg::ST_PR_MUL: begin
        term_nxt = $signed(s_rdata) * delta_r;
      end
      ssg_pkg::ST_PR_ACC: begin
        score_nxt = sc_sat;
      end
      ssg_pkg::ST_FIN_WALK: begin
        s_we    = 1'b1;
        s_waddr = l_rdata;
        if (walk_r == count_r) begin
          walk_nxt  = '0;
          count_nxt = '0;
        end else begin
          walk_nxt = walk_r + 1'b1;
        end
      end
      default: pop_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ssg_pkg::ST_CLEAR;
      clr_r   <= '0;
      count_r <= '0;
      walk_r  <= '0;
      score_r <= '0;
      ovf_r   <= 1'b0;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      count_r <= count_nxt;
      walk_r  <= walk_nxt;
      score_r <= score_nxt;
      ovf_r   <= ovf_nxt;
      oval_r  <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r   <= addr_nxt;
    delta_r  <= delta_nxt;
    term_r   <= term_nxt;
    oscore_r <= oscore_nxt;
    oovf_r   <= oovf_nxt;
  end

  assign stat.clearing = state_r == ssg_pkg::ST_CLEAR;
  assign out_tvalid    = oval_r;
  assign out_tdata     = oscore_r;
  assign out_tuser     = oovf_r;

endmodule

[hw/rtl/sparse_scatter_gather_dot_product_core.sv]
// Sparse feature-vector dot product, scatter/gather over a dense scratch RAM.
// Input channel (in_*): one item per feature. tuser selects the action
// (load, probe, finish) and the feature kind; tdata carries index and value.
// Loads accumulate the first vector into scratch, probes multiply scratch
// entries into a running score, a finish emits one result on out_*.
// Result channel (out_*): saturated score in tdata, list-overflow in tuser.
// Items are accepted into a four-entry queue in front of the execute unit,
// so the input keeps flowing while the back end is busy, until the queue fills.
// Execute steps, set by the registered-read scratch RAM read-modify-write:
// a load reads scratch, then writes the saturated sum (a load on a full
// list is dropped and sets list-overflow); a probe reads scratch,
// multiplies, then accumulates; a finish emits its result while the
// touched list is walked and those scratch entries are zeroed.
// Dropped items (unknown codes, out-of-range index) are consumed at input.
// A stalled result stays in the output register; the next finish waits at
// the head of the queue and holds back the items queued behind it.
// Reset: the scratch RAM is zeroed, one entry per cycle, all min(NUM_FEATURES,
// 65536) entries, with in_tready low until the pass completes.
module sparse_scatter_gather_dot_product_core #(
  parameter int NUM_FEATURES = 65536,
  parameter int MAX_LOADED   = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // feature_index[15:0], feature_value[31:16]
  input  logic [3:0]  in_tuser,   // action[1:0], kind[3:2]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // score[47:0]
  output logic [0:0]  out_tuser   // list_overflow[0]
);

  ssg_pkg::back_stat_t stat;
  logic                push_valid;
  logic                push_ready;
  ssg_pkg::op_t        push_op;
  logic                pop_valid;
  logic                pop_ready;
  ssg_pkg::op_t        pop_op;

  ssg_front #(.NUM_FEATURES(NUM_FEATURES)) u_front (
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .stat       (stat),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_op    (push_op)
  );

  ssg_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_op    (push_op),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_op     (pop_op)
  );

  ssg_back #(.NUM_FEATURES(NUM_FEATURES), .MAX_LOADED(MAX_LOADED)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_op     (pop_op),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

[hw/rtl/ssg_checker.sv]
`include "sparse_scatter_gather_dot_product_core_defines.svh"

module ssg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic [0:0]  out_tuser
);

  // result held while stalled
  `SSG_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid)
  `SSG_ASSERT(a_out_data_stable, clk, rst_n, out_tvalid && !out_tready |=> $stable(out_tdata))
  `SSG_ASSERT(a_out_user_stable, clk, rst_n, out_tvalid && !out_tready |=> $stable(out_tuser))

  // scratch clear starts at reset: no input taken, no stale result
  `SSG_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> !in_tready && !out_tvalid)

  // a finish needs the queue and execute stage: no result the cycle after reset release
  `SSG_ASSERT_ALWAYS(a_no_early_result, clk, !rst_n ##1 rst_n |-> !out_tvalid)

endmodule

bind sparse_scatter_gather_dot_product_core ssg_checker u_ssg_checker (.*);

[dv/tb.sv]
`timescale 1ns / 1ps

module tb;

  localparam int          LIST_DEPTH     = 256;
  localparam int          WATCHDOG_LIMIT = 200000;
  localparam int          DRAIN_CYCLES   = 2 * LIST_DEPTH + 50;
  localparam logic [1:0]  ACT_UNUSED     = 2'd3;

  typedef struct {
    logic [ssg_pkg::SCORE_W-1:0] score;
    logic                        list_overflow;
  } dot_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // feature_index[15:0], feature_value[31:16]
  logic [3:0]  in_tuser = '0;   // action[1:0], kind[3:2]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;       // score[47:0]
  logic [0:0]  out_tuser;       // list_overflow[0]

  // predictor state
  logic signed [ssg_pkg::SCR_W-1:0] scratch_sums [0:65535];
  logic [ssg_pkg::IDX_W-1:0]        touched_q [$];
  longint                           score_acc;
  logic                             ovf_flag;
  dot_result_t                      pending_scores [$];

  int in_idle_pct;
  int out_idle_pct;
  int items_sent;
  int results_seen = 0;
  int err_count = 0;
  int quiet_cycles = 0;

  sparse_scatter_gather_dot_product_core #(
    .NUM_FEATURES(65536),
    .MAX_LOADED  (LIST_DEPTH)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic signed [ssg_pkg::VAL_W-1:0] clamp_q11(
    input logic signed [ssg_pkg::VAL_W-1:0] v);
    if (v > ssg_pkg::TWO_Q11) return ssg_pkg::TWO_Q11;
    if (v < ssg_pkg::NEG_TWO_Q11) return ssg_pkg::NEG_TWO_Q11;
    return v;
  endfunction

  function automatic void predict_dot(input logic [1:0] act, input logic [1:0] kind,
                                      input logic [ssg_pkg::IDX_W-1:0] idx,
                                      input logic signed [ssg_pkg::VAL_W-1:0] val);
    logic signed [ssg_pkg::VAL_W-1:0] delta;
    int                               s;
    longint                           entry;
    longint                           term;
    longint                           sum;
    dot_result_t                      res;
    case (act)
      ssg_pkg::ACT_LOAD: begin
        if (kind == ssg_pkg::KIND_UNUSED) return;
        if (touched_q.size() >= LIST_DEPTH) begin
          ovf_flag = 1'b1;
          return;
        end
        case (kind)
          ssg_pkg::KIND_BIN: delta = ssg_pkg::ONE_Q11;
          ssg_pkg::KIND_NEG: delta = ssg_pkg::NEG_ONE_Q11;
          default:           delta = clamp_q11(val);
        endcase
        s = scratch_sums[idx] + delta;
        if (s > ssg_pkg::SCR_MAX) s = ssg_pkg::SCR_MAX;
        if (s < ssg_pkg::SCR_MIN) s = ssg_pkg::SCR_MIN;
        scratch_sums[idx] = s[ssg_pkg::SCR_W-1:0];
        touched_q = {touched_q, idx};
      end
      ssg_pkg::ACT_PROBE: begin
        if (kind == ssg_pkg::KIND_UNUSED) return;
        entry = scratch_sums[idx];
        case (kind)
          ssg_pkg::KIND_BIN: term = entry * ssg_pkg::ONE_Q11;
          ssg_pkg::KIND_NEG: term = -(entry * ssg_pkg::ONE_Q11);
          default:           term = entry * clamp_q11(val);
        endcase
        sum = score_acc + term;
        if (sum > ssg_pkg::SCORE_MAX) sum = ssg_pkg::SCORE_MAX;
        if (sum < ssg_pkg::SCORE_MIN) sum = ssg_pkg::SCORE_MIN;
        score_acc = sum;
      end
      ssg_pkg::ACT_FINISH: begin
        res.score         = score_acc[ssg_pkg::SCORE_W-1:0];
        res.list_overflow = ovf_flag;
        pending_scores    = {pending_scores, res};
        foreach (touched_q[i]) scratch_sums[touched_q[i]] = '0;
        touched_q.delete();
        score_acc = 0;
        ovf_flag  = 1'b0;
      end
      default: ;
    endcase
  endfunction

  task automatic send_item(input logic [1:0] act, input logic [1:0] kind,
                           input logic [ssg_pkg::IDX_W-1:0] idx,
                           input logic signed [ssg_pkg::VAL_W-1:0] val);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {val, idx};
    in_tuser  <= {kind, act};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_dot(act, kind, idx, val);
    items_sent++;
  endtask

  function automatic logic [1:0] rand_kind();
    case ($urandom_range(2))
      0:       return ssg_pkg::KIND_BIN;
      1:       return ssg_pkg::KIND_NEG;
      default: return ssg_pkg::KIND_WGT;
    endcase
  endfunction

  function automatic logic [ssg_pkg::IDX_W-1:0] rand_index(
    input logic [ssg_pkg::IDX_W-1:0] base);
    if ($urandom_range(3) == 0) return ssg_pkg::IDX_W'($urandom);
    return base + ssg_pkg::IDX_W'($urandom_range(15));
  endfunction

  function automatic logic signed [ssg_pkg::VAL_W-1:0] rand_value();
    case ($urandom_range(3))
      0: return ssg_pkg::VAL_W'($urandom);
      1: return ssg_pkg::VAL_W'($urandom_range(8192)) - 16'sd4096;
      2: begin
        case ($urandom_range(3))
          0:       return 16'sh7FFF;
          1:       return 16'sh8000;
          2:       return ssg_pkg::TWO_Q11;
          default: return ssg_pkg::NEG_TWO_Q11;
        endcase
      end
      default: return ssg_pkg::VAL_W'($urandom_range(64)) - 16'sd32;
    endcase
  endfunction

  // unknown action, or load/probe with unknown kind
  task automatic maybe_noise();
    if ($urandom_range(19) != 0) return;
    case ($urandom_range(2))
      0: send_item(ACT_UNUSED, 2'($urandom), ssg_pkg::IDX_W'($urandom),
                   ssg_pkg::VAL_W'($urandom));
      1: send_item(ssg_pkg::ACT_LOAD, ssg_pkg::KIND_UNUSED, ssg_pkg::IDX_W'($urandom),
                   ssg_pkg::VAL_W'($urandom));
      default: send_item(ssg_pkg::ACT_PROBE, ssg_pkg::KIND_UNUSED,
                         ssg_pkg::IDX_W'($urandom), ssg_pkg::VAL_W'($urandom));
    endcase
  endtask

  task automatic test_directed();
    send_item(ssg_pkg::ACT_FINISH, ssg_pkg::KIND_BIN, '0, '0);
    send_item(ssg_pkg::ACT_LOAD, ssg_pkg::KIND_BIN, 16'h0000, '0);
    send_item(ssg_pkg::ACT_LOAD, ssg_pkg::KIND_NEG, 16'hFFFF, '0);
    send_item(ssg_pkg::ACT_LOAD, ssg_pkg::KIND_WGT, 16'h1234, 16'sh7FFF);
    send_item(ssg_pkg::ACT_LOAD, ssg_pkg::KIND_WGT, 16'h1234, 16'sh8000);
    send_item(ssg_pkg::ACT_LOAD, ssg_pkg::KIND_WGT, 16'hA5A5, ssg_pkg::TWO_Q11);
    send_item(ssg_pkg::ACT_LOAD, ssg_pkg::KIND_WGT, 16'h5A5A, ssg_pkg::NEG_TWO_Q11);
    send_item(ssg_pkg::ACT_LOAD, ssg_pkg::KIND_WGT, 16'h5A5A, 16'sd4097);
    send_item(ssg_pkg::ACT_LOAD, ssg_pkg::KIND_UNUSED, 16'h0000, 16'sh7FFF);
    send_item(ACT_UNUSED, ssg_pkg::KIND_WGT, 16'h0000, 16'sh7FFF);
    send_item(ssg_pkg::ACT_PROBE, ssg_pkg::KIND_BIN, 16'h0000, '0);
    send_item(ssg_pkg::ACT_PROBE, ssg_pkg::KIND_NEG, 16'hFFFF, '0);
    send_item(ssg_pkg::ACT_PROBE, ssg_pkg::KIND_WGT, 16'hA5A5, 16'sh7FFF);
    send_item(ssg_pkg::ACT_PROBE, ssg_pkg::KIND_WGT, 16'h5A5A, 16'sh8000);
    send_item(ssg_pkg::ACT_PROBE, ssg_pkg::KIND_WGT, 16'h1234, 16'sd1234);
    send_item(ssg_pkg::ACT_PROBE, ssg_pkg::KIND_BIN, 16'h7777, '0);
    send_item(ssg_pkg::ACT_PROBE, ssg_pkg::KIND_UNUSED, 16'h0000, 16'sh7FFF);
    send_item(ssg_pkg::ACT_FINISH, ssg_pkg::KIND_WGT, 16'hFFFF, 16'sh7FFF);
    send_item(ssg_pkg::ACT_PROBE, ssg_pkg::KIND_BIN, 16'h0000, '0);
    send_item(ssg_pkg::ACT_FINISH, ssg_pkg::KIND_UNUSED, '0, '0);
  endtask

  task automatic test_list_overflow();
    logic [ssg_pkg::IDX_W-1:0] base;
    base = ssg_pkg::IDX_W'($urandom);
    // full list, then an unknown-kind load: must not flag
    repeat (LIST_DEPTH) send_item(ssg_pkg::ACT_LOAD, rand_kind(), rand_index(base),
                                  rand_value());
    send_item(ssg_pkg::ACT_LOAD, ssg_pkg::KIND_UNUSED, base, 16'sd100);
    send_item(ssg_pkg::ACT_PROBE, ssg_pkg::KIND_BIN, base, '0);
    send_item(ssg_pkg::ACT_FINISH, ssg_pkg::KIND_BIN, '0, '0);
    // full list, then dropped loads on an already touched index
    repeat (LIST_DEPTH) send_item(ssg_pkg::ACT_LOAD, ssg_pkg::KIND_BIN, base, '0);
    repeat (3) send_item(ssg_pkg::ACT_LOAD, ssg_pkg::KIND_WGT, base, ssg_pkg::TWO_Q11);
    send_item(ssg_pkg::ACT_PROBE, ssg_pkg::KIND_WGT, base, ssg_pkg::TWO_Q11);
    send_item(ssg_pkg::ACT_FINISH, ssg_pkg::KIND_BIN, '0, '0);
    send_item(ssg_pkg::ACT_PROBE, ssg_pkg::KIND_BIN, base, '0);
    send_item(ssg_pkg::ACT_FINISH, ssg_pkg::KIND_BIN, '0, '0);
  endtask

  task automatic test_random(input int n_items);
    int                        done_items;
    int                        n_ld;
    int                        n_pr;
    logic [ssg_pkg::IDX_W-1:0] base;
    done_items = 0;
    while (done_items < n_items) begin
      base = ssg_pkg::IDX_W'($urandom);
      n_ld = ($urandom_range(19) == 0) ? $urandom_range(240, 280) : $urandom_range(20);
      n_pr = $urandom_range(20);
      repeat (n_ld) begin
        maybe_noise();
        send_item(ssg_pkg::ACT_LOAD, rand_kind(), rand_index(base), rand_value());
      end
      repeat (n_pr) begin
        maybe_noise();
        send_item(ssg_pkg::ACT_PROBE, rand_kind(), rand_index(base), rand_value());
      end
      // occasionally leave the vector open so the next one stacks on it
      if ($urandom_range(9) != 0) send_item(ssg_pkg::ACT_FINISH, 2'($urandom),
                                            ssg_pkg::IDX_W'($urandom),
                                            ssg_pkg::VAL_W'($urandom));
      done_items += n_ld + n_pr + 1;
    end
  endtask

  always @(posedge clk) begin
    dot_result_t exp_res;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (pending_scores.size() == 0) begin
        $error("result with no finish outstanding: score %0d", $signed(out_tdata));
        err_count++;
      end else begin
        exp_res = pending_scores.pop_front();
        if (out_tdata !== exp_res.score) begin
          $error("score mismatch: expected %0d, got %0d", $signed(exp_res.score),
                 $signed(out_tdata));
          err_count++;
        end
        if (out_tuser[0] !== exp_res.list_overflow) begin
          $error("list_overflow mismatch: expected %0b, got %0b", exp_res.list_overflow,
                 out_tuser[0]);
          err_count++;
        end
      end
    end
    out_tready <= ($urandom_range(99) >= out_idle_pct);

    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    foreach (scratch_sums[i]) scratch_sums[i] = '0;
    score_acc    = 0;
    ovf_flag     = 1'b0;
    items_sent   = 0;
    in_idle_pct  = 21;
    out_idle_pct = 50;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_list_overflow();
    test_random(200);

    in_idle_pct  = 50;
    out_idle_pct = 21;
    test_random(200);

    in_idle_pct  = 0;
    out_idle_pct = 0;
    test_random(200);

    in_tvalid <= 1'b0;
    wait (pending_scores.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d items, checked %0d dot-product results.", items_sent, results_seen);
    $display("Covered clamping, unknown codes, touched-list overflow and stalled traffic.");
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
